[rtl/core/ddarc_pkg.sv]
// ----------------------------------------------------------------------------
// ddarc_pkg
// Shared constants, types and register codes of the column raycaster.
// ----------------------------------------------------------------------------
package ddarc_pkg;

    localparam int SCREEN_WIDTH  = 640;
    localparam int SCREEN_HEIGHT = 480;
    localparam int MAP_SIDE      = 64;
    localparam int MAX_STEPS     = 128;

    localparam int MAP_DEPTH = MAP_SIDE * MAP_SIDE;
    localparam int ADDR_W    = $clog2(MAP_DEPTH);
    localparam int STEP_W    = $clog2(MAX_STEPS + 1);
    localparam int CRD_W     = 10;               // signed cell coordinate
    localparam int QDEPTH    = 2;                // front queue entries

    // camera term column*32768/SCREEN_WIDTH = column*CAM_WHOLE + column/5;
    // the column/5 part is a reciprocal multiply, exact for 10-bit columns
    localparam int CAM_WHOLE    = 32768 / SCREEN_WIDTH;
    localparam int CAM_RECIP    = 205;
    localparam int CAM_RECIP_SH = 10;

    localparam logic [31:0] DIST_CAP = 32'hFFFF_FFFF;
    localparam logic [15:0] PERP_CAP = 16'hFFFF;

    // configuration register indexes
    localparam logic [2:0] CFG_PLAYER_X = 3'd0;
    localparam logic [2:0] CFG_PLAYER_Y = 3'd1;
    localparam logic [2:0] CFG_DIR_X    = 3'd2;
    localparam logic [2:0] CFG_DIR_Y    = 3'd3;
    localparam logic [2:0] CFG_PLANE_X  = 3'd4;
    localparam logic [2:0] CFG_PLANE_Y  = 3'd5;

    // request codes
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_CAST  = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [9:0] column;
        logic [5:0] cell_x;
        logic [5:0] cell_y;
        logic       cell_is_wall;
    } t_item;

    typedef struct packed {
        logic        [13:0] player_x;
        logic        [13:0] player_y;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] plane_x;
        logic signed [15:0] plane_y;
    } t_cfg;

    typedef struct packed {
        logic ready;
        logic clearing;
    } t_bk_status;

endpackage

[rtl/core/ddarc_ram.sv]
// ----------------------------------------------------------------------------
// ddarc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ddarc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/ddarc_div.sv]
// ----------------------------------------------------------------------------
// ddarc_div
// Shared restoring divider, 32-bit dividend by 20-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module ddarc_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [31:0] i_num,
    input  logic [19:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quo
);

    logic [31:0] r_num, n_num;
    logic [19:0] r_den;
    logic [19:0] r_rem, n_rem;
    logic [5:0]  r_cnt;
    logic        r_done;
    logic [20:0] rem_sh;
    logic [20:0] rem_sub;
    logic        q_bit;

    always_comb begin
        rem_sh  = {r_rem, r_num[31]};
        rem_sub = rem_sh - {1'b0, r_den};
        q_bit   = (rem_sh >= {1'b0, r_den});
        n_rem   = q_bit ? rem_sub[19:0] : rem_sh[19:0];
        n_num   = {r_num[30:0], q_bit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_cnt <= 6'd32;
            end else if (r_cnt != 6'd0) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_cnt != 6'd0) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;

endmodule

[rtl/core/ddarc_front.sv]
// ----------------------------------------------------------------------------
// ddarc_front
// Accepts request words and queues them for the cast engine.
// ----------------------------------------------------------------------------
module ddarc_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  ddarc_pkg::t_item      i_item,
    output logic                  o_busy,
    input  ddarc_pkg::t_bk_status i_bk,
    output logic                  o_pop,
    output ddarc_pkg::t_item      o_item
);

    localparam int PTR_W = $clog2(ddarc_pkg::QDEPTH);

    ddarc_pkg::t_item r_q [ddarc_pkg::QDEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [PTR_W:0]   r_cnt;
    logic             push;

    assign o_busy = (r_cnt == (PTR_W+1)'(ddarc_pkg::QDEPTH)) || i_bk.clearing;
    assign push   = i_start && !o_busy;
    assign o_pop  = (r_cnt != '0) && i_bk.ready;
    assign o_item = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PTR_W'(ddarc_pkg::QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (o_pop) begin
                r_rp <= (r_rp == PTR_W'(ddarc_pkg::QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PTR_W+1)'(push) - (PTR_W+1)'(o_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_item;
        end
    end

endmodule

[rtl/core/ddarc_back.sv]
// ----------------------------------------------------------------------------
// ddarc_back
// Cast engine: map writes, ray setup, DDA walk, distance and span.
// ----------------------------------------------------------------------------
module ddarc_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ddarc_pkg::t_cfg       i_cfg,
    input  logic                  i_pop,
    input  ddarc_pkg::t_item      i_item,
    output ddarc_pkg::t_bk_status o_bk,
    output logic                  o_valid,
    output logic [9:0]            o_out_column,
    output logic [8:0]            o_draw_start,
    output logic [8:0]            o_draw_end,
    output logic                  o_wall_side,
    output logic [5:0]            o_hit_x,
    output logic [5:0]            o_hit_y,
    output logic [15:0]           o_perp_distance,
    output logic                  o_no_hit
);

    localparam int AW = ddarc_pkg::ADDR_W;
    localparam int CW = ddarc_pkg::CRD_W;
    localparam int SW = ddarc_pkg::STEP_W;

    typedef enum logic [11:0] {
        ST_CLEAR = 12'b0000_0000_0001,
        ST_IDLE  = 12'b0000_0000_0010,
        ST_CAM   = 12'b0000_0000_0100,
        ST_MUL   = 12'b0000_0000_1000,
        ST_RAY   = 12'b0000_0001_0000,
        ST_DX    = 12'b0000_0010_0000,
        ST_DY    = 12'b0000_0100_0000,
        ST_SIDE  = 12'b0000_1000_0000,
        ST_STEP  = 12'b0001_0000_0000,
        ST_TEST  = 12'b0010_0000_0000,
        ST_PERP  = 12'b0100_0000_0000,
        ST_SPAN  = 12'b1000_0000_0000
    } t_state;

    function automatic logic [19:0] abs_r(input logic signed [20:0] v);
        logic [20:0] t;
        t = v[20] ? 21'(-v) : 21'(v);
        return t[19:0];
    endfunction

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? ddarc_pkg::DIST_CAP : s[31:0];
    endfunction

    t_state r_state, n_state;
    logic              r_go, n_go;
    logic [AW-1:0]     r_clr;
    logic [9:0]        r_column;
    logic signed [16:0] r_cam;
    logic signed [32:0] r_prx, r_pry;
    logic signed [20:0] r_rx, r_ry;
    logic [31:0]       r_dx, r_dy, r_sx, r_sy, n_sx, n_sy;
    logic signed [CW-1:0] r_mx, r_my, n_mx, n_my;
    logic              r_side, n_side;
    logic [SW-1:0]     r_steps;
    logic [15:0]       r_perp;
    logic              r_valid;

    // divider
    logic        div_done;
    logic [31:0] div_quo, div_num;
    logic [19:0] div_den;

    // map RAM
    logic          ram_we, ram_wdata, ram_rdata;
    logic [AW-1:0] ram_waddr, ram_raddr;

    // datapath helpers
    logic [15:0]        cam_q;
    logic signed [32:0] tq_x, tq_y;
    logic signed [20:0] ray_x, ray_y;
    logic [8:0]         frac_x, frac_y;
    logic [40:0]        sprod_x, sprod_y;
    logic signed [23:0] pnum;
    logic [23:0]        pabs;
    logic [19:0]        pden;
    logic               out_of_map;
    logic               cast_in_map;
    logic [16:0]        half;
    logic [16:0]        de_raw;

    assign o_bk.ready    = (r_state == ST_IDLE);
    assign o_bk.clearing = (r_state == ST_CLEAR);

    // camera term column*32768/width, truncated
    // ray = dir + plane*cam/16384, truncated toward zero
    always_comb begin
        cam_q  = 16'({6'b0, r_column} * 16'(ddarc_pkg::CAM_WHOLE))
               + 16'(({10'b0, r_column} * 20'(ddarc_pkg::CAM_RECIP)) >> ddarc_pkg::CAM_RECIP_SH);
        tq_x   = (r_prx < 0) ? ((r_prx + 33'sd16383) >>> 14) : (r_prx >>> 14);
        tq_y   = (r_pry < 0) ? ((r_pry + 33'sd16383) >>> 14) : (r_pry >>> 14);
        ray_x  = 21'(i_cfg.dir_x) + tq_x[20:0];
        ray_y  = 21'(i_cfg.dir_y) + tq_y[20:0];
        frac_x = r_rx[20] ? {1'b0, i_cfg.player_x[7:0]} : 9'd256 - {1'b0, i_cfg.player_x[7:0]};
        frac_y = r_ry[20] ? {1'b0, i_cfg.player_y[7:0]} : 9'd256 - {1'b0, i_cfg.player_y[7:0]};
        sprod_x = 41'(frac_x) * 41'(r_dx);
        sprod_y = 41'(frac_y) * 41'(r_dy);
    end

    // perpendicular distance numerator on the crossed axis
    always_comb begin
        if (!r_side) begin
            pnum = $signed({{6{r_mx[CW-1]}}, r_mx, 8'b0}) - $signed({10'b0, i_cfg.player_x})
                   + (r_rx[20] ? 24'sd256 : 24'sd0);
            pden = abs_r(r_rx);
        end else begin
            pnum = $signed({{6{r_my[CW-1]}}, r_my, 8'b0}) - $signed({10'b0, i_cfg.player_y})
                   + (r_ry[20] ? 24'sd256 : 24'sd0);
            pden = abs_r(r_ry);
        end
        pabs = pnum[23] ? 24'(-pnum) : 24'(pnum);
    end

    // divider operand select
    always_comb begin
        case (r_state)
            ST_DX: begin
                div_num = 32'd4194304;
                div_den = abs_r(r_rx);
            end
            ST_DY: begin
                div_num = 32'd4194304;
                div_den = abs_r(r_ry);
            end
            ST_PERP: begin
                div_num = {pabs[17:0], 14'b0};
                div_den = pden;
            end
            default: begin
                div_num = 32'(ddarc_pkg::SCREEN_HEIGHT * 256);
                div_den = {4'b0, r_perp};
            end
        endcase
    end

    // one DDA step
    always_comb begin
        n_sx   = r_sx;
        n_sy   = r_sy;
        n_mx   = r_mx;
        n_my   = r_my;
        n_side = r_side;
        if (r_sx < r_sy) begin
            n_sx   = sat_add(r_sx, r_dx);
            n_mx   = r_rx[20] ? r_mx - CW'(1) : r_mx + CW'(1);
            n_side = 1'b0;
        end else begin
            n_sy   = sat_add(r_sy, r_dy);
            n_my   = r_ry[20] ? r_my - CW'(1) : r_my + CW'(1);
            n_side = 1'b1;
        end
        out_of_map = n_mx[CW-1] || n_my[CW-1]
                  || (n_mx >= CW'(ddarc_pkg::MAP_SIDE)) || (n_my >= CW'(ddarc_pkg::MAP_SIDE));
        cast_in_map = ({2'b0, i_cfg.player_x[13:8]} < 8'(ddarc_pkg::MAP_SIDE))
                   && ({2'b0, i_cfg.player_y[13:8]} < 8'(ddarc_pkg::MAP_SIDE));
        half   = div_quo[17:1];
        de_raw = half + 17'(ddarc_pkg::SCREEN_HEIGHT / 2);
    end

    // map RAM ports: clear sweep and write items share the write port
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_clr;
        ram_wdata = 1'b0;
        if (r_state == ST_CLEAR) begin
            ram_we = 1'b1;
        end else if ((r_state == ST_IDLE) && i_pop && (i_item.req_type == ddarc_pkg::REQ_WRITE)
                     && ({4'b0, i_item.cell_x} < 10'(ddarc_pkg::MAP_SIDE))
                     && ({4'b0, i_item.cell_y} < 10'(ddarc_pkg::MAP_SIDE))) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(int'(i_item.cell_y) * ddarc_pkg::MAP_SIDE + int'(i_item.cell_x));
            ram_wdata = i_item.cell_is_wall;
        end
        ram_raddr = AW'(int'(n_my[CW-2:0]) * ddarc_pkg::MAP_SIDE + int'(n_mx[CW-2:0]));
    end

    always_comb begin
        n_state = r_state;
        n_go    = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == AW'(ddarc_pkg::MAP_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_pop && (i_item.req_type == ddarc_pkg::REQ_CAST)) begin
                    n_state = ST_CAM;
                end
            end
            ST_CAM:  n_state = ST_MUL;
            ST_MUL:  n_state = ST_RAY;
            ST_RAY: begin
                n_state = ST_DX;
                n_go    = 1'b1;
            end
            ST_DX: begin
                if (div_done) begin
                    n_state = ST_DY;
                    n_go    = 1'b1;
                end
            end
            ST_DY: begin
                if (div_done) n_state = ST_SIDE;
            end
            ST_SIDE: n_state = cast_in_map ? ST_STEP : ST_IDLE;
            ST_STEP: begin
                if ((r_steps == SW'(ddarc_pkg::MAX_STEPS)) || out_of_map) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_TEST;
                end
            end
            ST_TEST: begin
                if (ram_rdata) begin
                    n_state = ST_PERP;
                    n_go    = 1'b1;
                end else begin
                    n_state = ST_STEP;
                end
            end
            ST_PERP: begin
                if (div_done) begin
                    if ((pden == '0) || (div_quo[31:16] != '0) || (div_quo[15:0] != '0)) begin
                        n_state = ST_SPAN;
                        n_go    = 1'b1;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_SPAN: if (div_done) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_go    <= 1'b0;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= n_go;
            r_valid <= 1'b0;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (((r_state == ST_SIDE) && !cast_in_map)
                || ((r_state == ST_STEP) && (n_state == ST_IDLE))
                || ((r_state == ST_PERP) && (n_state == ST_IDLE))
                || ((r_state == ST_SPAN) && div_done)) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_pop) r_column <= i_item.column;
            end
            ST_CAM: begin
                r_cam <= $signed({1'b0, cam_q}) - 17'sd16384;
            end
            ST_MUL: begin
                r_prx <= 33'(i_cfg.plane_x) * 33'(r_cam);
                r_pry <= 33'(i_cfg.plane_y) * 33'(r_cam);
            end
            ST_RAY: begin
                r_rx <= ray_x;
                r_ry <= ray_y;
            end
            ST_DX: begin
                if (div_done) r_dx <= (r_rx == '0) ? ddarc_pkg::DIST_CAP : div_quo;
            end
            ST_DY: begin
                if (div_done) r_dy <= (r_ry == '0) ? ddarc_pkg::DIST_CAP : div_quo;
            end
            ST_SIDE: begin
                r_sx    <= sprod_x[39:8];
                r_sy    <= sprod_y[39:8];
                r_mx    <= CW'({2'b0, i_cfg.player_x[13:8]});
                r_my    <= CW'({2'b0, i_cfg.player_y[13:8]});
                r_side  <= 1'b0;
                r_steps <= '0;
            end
            ST_STEP: begin
                r_sx    <= n_sx;
                r_sy    <= n_sy;
                r_mx    <= n_mx;
                r_my    <= n_my;
                r_side  <= n_side;
                r_steps <= r_steps + 1'b1;
            end
            ST_PERP: begin
                if (div_done) begin
                    if ((pden == '0) || (div_quo[31:16] != '0)) begin
                        r_perp <= ddarc_pkg::PERP_CAP;
                    end else begin
                        r_perp <= div_quo[15:0];
                    end
                end
            end
            default: ;
        endcase
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (((r_state == ST_SIDE) && !cast_in_map)
            || ((r_state == ST_STEP) && (n_state == ST_IDLE))) begin
            o_out_column    <= r_column;
            o_draw_start    <= '0;
            o_draw_end      <= '0;
            o_wall_side     <= 1'b0;
            o_hit_x         <= '0;
            o_hit_y         <= '0;
            o_perp_distance <= ddarc_pkg::PERP_CAP;
            o_no_hit        <= 1'b1;
        end else if (((r_state == ST_PERP) && (n_state == ST_IDLE))
                     || ((r_state == ST_SPAN) && div_done)) begin
            o_out_column    <= r_column;
            o_wall_side     <= r_side;
            o_hit_x         <= r_mx[5:0];
            o_hit_y         <= r_my[5:0];
            o_no_hit        <= 1'b0;
            if (r_state == ST_PERP) begin
                // zero distance: span covers the whole column
                o_perp_distance <= '0;
                o_draw_start    <= '0;
                o_draw_end      <= 9'(ddarc_pkg::SCREEN_HEIGHT - 1);
            end else begin
                o_perp_distance <= r_perp;
                o_draw_start    <= (half >= 17'(ddarc_pkg::SCREEN_HEIGHT / 2)) ? '0
                                   : 9'(17'(ddarc_pkg::SCREEN_HEIGHT / 2) - half);
                o_draw_end      <= (de_raw >= 17'(ddarc_pkg::SCREEN_HEIGHT))
                                   ? 9'(ddarc_pkg::SCREEN_HEIGHT - 1) : de_raw[8:0];
            end
        end
    end

    assign o_valid = r_valid;

    ddarc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_go),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    ddarc_ram #(
        .WIDTH (1),
        .DEPTH (ddarc_pkg::MAP_DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    a_steps_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STEP) |-> (r_steps <= SW'(ddarc_pkg::MAX_STEPS)))
        else $error("step count beyond limit");

    a_test_after_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TEST) |-> ($past(r_state) == ST_STEP))
        else $error("map test without a step");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !i_pop)
        else $error("item taken during map clear");

endmodule

[rtl/core/dda_grid_raycast_column_core.sv]
// ----------------------------------------------------------------------------
// dda_grid_raycast_column_core
// Grid raycaster that returns one wall stripe per cast screen column.
// ----------------------------------------------------------------------------
// Usage:
//  - Request words enter on start/busy: a word is taken at a clock edge with
//    start high and busy low. req_type selects a map cell write or a cast.
//  - A two-word queue sits in front of the cast engine, so new words are
//    taken while a cast is running until the queue fills.
//  - Each cast returns one result word, strobed by o_valid for one cycle.
//    The receiver cannot stall: results are never held back or repeated.
//    Map writes return nothing.
//  - Configuration: i_cfg_valid/o_cfg_ready with a register index (0 player
//    x, 1 player y, 2/3 direction, 4/5 camera plane). o_cfg_ready is always
//    high; write only while the block is idle.
//  - Cast sequence: the camera term is a constant reciprocal multiply;
//    then the two delta divisions on the shared radix-2 divider, the
//    grid steps, and the distance and line-height divisions. A miss
//    skips the last two divisions, and a hit at zero distance skips the
//    line-height division. Casts run one at a time; a write is done by
//    the engine in its idle state as the word is popped.
//  - Reset: a clearing pass sweeps all 4096 map cells to open; busy is
//    high until it ends. Config registers return to their reset values.
// ----------------------------------------------------------------------------
module dda_grid_raycast_column_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_req_type,
    input  logic [9:0]  i_column,
    input  logic [5:0]  i_cell_x,
    input  logic [5:0]  i_cell_y,
    input  logic        i_cell_is_wall,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    output logic [9:0]  o_out_column,
    output logic [8:0]  o_draw_start,
    output logic [8:0]  o_draw_end,
    output logic        o_wall_side,
    output logic [5:0]  o_hit_x,
    output logic [5:0]  o_hit_y,
    output logic [15:0] o_perp_distance,
    output logic        o_no_hit
);

    ddarc_pkg::t_cfg       r_cfg;
    ddarc_pkg::t_item      in_item, q_item;
    ddarc_pkg::t_bk_status bk;
    logic                  pop;

    assign o_cfg_ready = 1'b1;

    // config registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.player_x <= 14'd512;
            r_cfg.player_y <= 14'd512;
            r_cfg.dir_x    <= -16'sd16384;
            r_cfg.dir_y    <= 16'sd0;
            r_cfg.plane_x  <= 16'sd0;
            r_cfg.plane_y  <= 16'sd10813;   // 0.66 in Q2.14
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ddarc_pkg::CFG_PLAYER_X: r_cfg.player_x <= i_cfg_data[13:0];
                ddarc_pkg::CFG_PLAYER_Y: r_cfg.player_y <= i_cfg_data[13:0];
                ddarc_pkg::CFG_DIR_X:    r_cfg.dir_x    <= i_cfg_data;
                ddarc_pkg::CFG_DIR_Y:    r_cfg.dir_y    <= i_cfg_data;
                ddarc_pkg::CFG_PLANE_X:  r_cfg.plane_x  <= i_cfg_data;
                ddarc_pkg::CFG_PLANE_Y:  r_cfg.plane_y  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign in_item.req_type     = i_req_type;
    assign in_item.column       = i_column;
    assign in_item.cell_x       = i_cell_x;
    assign in_item.cell_y       = i_cell_y;
    assign in_item.cell_is_wall = i_cell_is_wall;

    // front: accept and queue
    ddarc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (in_item),
        .o_busy  (busy),
        .i_bk    (bk),
        .o_pop   (pop),
        .o_item  (q_item)
    );

    // back: map writes and casts in queue order
    ddarc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_pop           (pop),
        .i_item          (q_item),
        .o_bk            (bk),
        .o_valid         (o_valid),
        .o_out_column    (o_out_column),
        .o_draw_start    (o_draw_start),
        .o_draw_end      (o_draw_end),
        .o_wall_side     (o_wall_side),
        .o_hit_x         (o_hit_x),
        .o_hit_y         (o_hit_y),
        .o_perp_distance (o_perp_distance),
        .o_no_hit        (o_no_hit)
    );

endmodule

[tb/sv/raycast_checker.sv]
// ----------------------------------------------------------------------------
// raycast_checker
// Watches the request, config and result channels of the column raycaster,
// predicts each cast result from its own map and register copies, and
// compares every result word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module raycast_checker
    import ddarc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        i_req_type,
    input  logic [9:0]  i_column,
    input  logic [5:0]  i_cell_x,
    input  logic [5:0]  i_cell_y,
    input  logic        i_cell_is_wall,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    input  logic [9:0]  i_out_column,
    input  logic [8:0]  i_draw_start,
    input  logic [8:0]  i_draw_end,
    input  logic        i_wall_side,
    input  logic [5:0]  i_hit_x,
    input  logic [5:0]  i_hit_y,
    input  logic [15:0] i_perp_distance,
    input  logic        i_no_hit,
    output int          o_pending,
    output int          o_fails
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [9:0]  column;
        logic [8:0]  draw_start;
        logic [8:0]  draw_end;
        logic        wall_side;
        logic [5:0]  hit_x;
        logic [5:0]  hit_y;
        logic [15:0] perp;
        logic        no_hit;
    } t_stripe;

    localparam longint CAP = 64'hFFFF_FFFF;

    t_stripe stripe_q[$];
    bit      wall_map[MAP_SIDE][MAP_SIDE];
    t_cfg    cfg;

    assign o_pending = stripe_q.size();

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint grid_delta(longint r);
        if (r == 0) return CAP;
        return 4194304 / mag(r);
    endfunction

    // Q1.8 fraction to the first grid line in the ray's direction
    function automatic longint first_frac(logic [13:0] pos, longint r);
        return (r < 0) ? longint'(pos[7:0]) : 256 - longint'(pos[7:0]);
    endfunction

    function automatic t_stripe cast_column(logic [9:0] col);
        longint  cam, rx, ry, dx, dy, sx, sy, perp, height, half, ds, de, num, ar;
        int      mx, my, stx, sty, side, n;
        bit      hit;
        t_stripe r;
        cam  = longint'(col) * 32768 / SCREEN_WIDTH - 16384;
        rx   = longint'(cfg.dir_x) + (longint'(cfg.plane_x) * cam) / 16384;
        ry   = longint'(cfg.dir_y) + (longint'(cfg.plane_y) * cam) / 16384;
        mx   = int'(cfg.player_x >> 8);
        my   = int'(cfg.player_y >> 8);
        dx   = grid_delta(rx);
        dy   = grid_delta(ry);
        stx  = (rx < 0) ? -1 : 1;
        sty  = (ry < 0) ? -1 : 1;
        sx   = first_frac(cfg.player_x, rx) * dx / 256;
        sy   = first_frac(cfg.player_y, ry) * dy / 256;
        side = 0;
        hit  = 0;
        if (mx < MAP_SIDE && my < MAP_SIDE) begin
            for (n = 0; n < MAX_STEPS; n++) begin
                // ties step in y
                if (sx < sy) begin
                    sx = (sx + dx > CAP) ? CAP : sx + dx;
                    mx += stx;
                    side = 0;
                end else begin
                    sy = (sy + dy > CAP) ? CAP : sy + dy;
                    my += sty;
                    side = 1;
                end
                if (mx < 0 || my < 0 || mx >= MAP_SIDE || my >= MAP_SIDE) break;
                if (wall_map[my][mx]) begin
                    hit = 1;
                    break;
                end
            end
        end
        r.column = col;
        if (!hit) begin
            r.draw_start = '0;
            r.draw_end   = '0;
            r.wall_side  = 0;
            r.hit_x      = '0;
            r.hit_y      = '0;
            r.perp       = PERP_CAP;
            r.no_hit     = 1;
            return r;
        end
        if (side == 0) begin
            num = longint'(mx) * 256 - longint'(cfg.player_x) + ((stx < 0) ? 256 : 0);
            ar  = mag(rx);
        end else begin
            num = longint'(my) * 256 - longint'(cfg.player_y) + ((sty < 0) ? 256 : 0);
            ar  = mag(ry);
        end
        if (ar == 0) perp = 65535;
        else begin
            perp = mag(num) * 16384 / ar;
            if (perp > 65535) perp = 65535;
        end
        // zero distance: unbounded height, whole column
        height = (perp == 0) ? CAP : longint'(SCREEN_HEIGHT) * 256 / perp;
        half   = height / 2;
        ds     = SCREEN_HEIGHT / 2 - half;
        if (ds < 0) ds = 0;
        de     = half + SCREEN_HEIGHT / 2;
        if (de >= SCREEN_HEIGHT) de = SCREEN_HEIGHT - 1;
        r.draw_start = ds[8:0];
        r.draw_end   = de[8:0];
        r.wall_side  = side[0];
        r.hit_x      = mx[5:0];
        r.hit_y      = my[5:0];
        r.perp       = perp[15:0];
        r.no_hit     = 0;
        return r;
    endfunction

    task automatic report(string field, longint got, longint want, logic [9:0] col);
        $display("%0t: column %0d field %s got %0d want %0d", $realtime, col, field,
                 got, want);
        o_fails++;
    endtask

    initial o_fails = 0;

    always @(posedge i_clk) begin
        t_stripe w;
        if (!i_rst_n) begin
            foreach (wall_map[y, x]) wall_map[y][x] = 0;
            cfg.player_x = 14'd512;
            cfg.player_y = 14'd512;
            cfg.dir_x    = -16'sd16384;
            cfg.dir_y    = 16'sd0;
            cfg.plane_x  = 16'sd0;
            cfg.plane_y  = 16'sd10813;
            stripe_q.delete();
        end else begin
            if (i_valid) begin
                if (stripe_q.size() == 0) begin
                    $display("%0t: unexpected result word for column %0d", $realtime,
                             i_out_column);
                    o_fails++;
                end else begin
                    w = stripe_q.pop_front();
                    if (i_out_column != w.column)
                        report("out_column", i_out_column, w.column, w.column);
                    if (i_draw_start != w.draw_start)
                        report("draw_start", i_draw_start, w.draw_start, w.column);
                    if (i_draw_end != w.draw_end)
                        report("draw_end", i_draw_end, w.draw_end, w.column);
                    if (i_wall_side != w.wall_side)
                        report("wall_side", i_wall_side, w.wall_side, w.column);
                    if (i_hit_x != w.hit_x)
                        report("hit_x", i_hit_x, w.hit_x, w.column);
                    if (i_hit_y != w.hit_y)
                        report("hit_y", i_hit_y, w.hit_y, w.column);
                    if (i_perp_distance != w.perp)
                        report("perp_distance", i_perp_distance, w.perp, w.column);
                    if (i_no_hit != w.no_hit)
                        report("no_hit", i_no_hit, w.no_hit, w.column);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PLAYER_X: cfg.player_x = i_cfg_data[13:0];
                    CFG_PLAYER_Y: cfg.player_y = i_cfg_data[13:0];
                    CFG_DIR_X:    cfg.dir_x    = i_cfg_data;
                    CFG_DIR_Y:    cfg.dir_y    = i_cfg_data;
                    CFG_PLANE_X:  cfg.plane_x  = i_cfg_data;
                    CFG_PLANE_Y:  cfg.plane_y  = i_cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy) begin
                if (i_req_type == REQ_WRITE)
                    wall_map[i_cell_y][i_cell_x] = i_cell_is_wall;
                else
                    stripe_q.push_back(cast_column(i_column));
            end
        end
    end
endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the column raycaster: map writes and casts under
// several camera settings, random start gaps, checked by raycast_checker.
// ----------------------------------------------------------------------------
module testbench;
    import ddarc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic        i_req_type = REQ_WRITE;
    logic [9:0]  i_column = '0;
    logic [5:0]  i_cell_x = '0;
    logic [5:0]  i_cell_y = '0;
    logic        i_cell_is_wall = 0;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        o_valid;
    logic [9:0]  o_out_column;
    logic [8:0]  o_draw_start;
    logic [8:0]  o_draw_end;
    logic        o_wall_side;
    logic [5:0]  o_hit_x;
    logic [5:0]  o_hit_y;
    logic [15:0] o_perp_distance;
    logic        o_no_hit;
    int          pending;
    int          fails;

    // player cell, used to aim map writes near the camera
    int          pcx = 2;
    int          pcy = 2;

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    dda_grid_raycast_column_core uut (.*);

    raycast_checker chk (
        .i_clk, .i_rst_n, .start, .busy, .i_req_type, .i_column, .i_cell_x,
        .i_cell_y, .i_cell_is_wall, .i_cfg_valid, .i_cfg_ready(o_cfg_ready),
        .i_cfg_index, .i_cfg_data, .i_valid(o_valid), .i_out_column(o_out_column),
        .i_draw_start(o_draw_start), .i_draw_end(o_draw_end),
        .i_wall_side(o_wall_side), .i_hit_x(o_hit_x), .i_hit_y(o_hit_y),
        .i_perp_distance(o_perp_distance), .i_no_hit(o_no_hit),
        .o_pending(pending), .o_fails(fails)
    );

    // Drive one request word and hold it until taken (busy low at the edge).
    task automatic send_word(logic req, logic [9:0] col, logic [5:0] cx,
                             logic [5:0] cy, logic wall);
        bit taken;
        start          <= 1;
        i_req_type     <= req;
        i_column       <= col;
        i_cell_x       <= cx;
        i_cell_y       <= cy;
        i_cell_is_wall <= wall;
        do begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic cast(logic [9:0] col);
        send_word(REQ_CAST, col, 6'($urandom), 6'($urandom), 1'($urandom));
    endtask

    task automatic put_cell(int x, int y, logic wall);
        send_word(REQ_WRITE, 10'($urandom), 6'(x), 6'(y), wall);
    endtask

    // Drop start, wait for every result, then let the engine settle:
    // a trailing map write may still be in flight.
    task automatic drain();
        start <= 0;
        do @(negedge i_clk); while (pending != 0);
        repeat (450) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [15:0] data);
        bit taken;
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(negedge i_clk);
            taken = o_cfg_ready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic load_camera(logic [13:0] px, logic [13:0] py, logic [15:0] dx,
                               logic [15:0] dy, logic [15:0] qx, logic [15:0] qy);
        cfg_write(CFG_PLAYER_X, 16'(px));
        cfg_write(CFG_PLAYER_Y, 16'(py));
        cfg_write(CFG_DIR_X, dx);
        cfg_write(CFG_DIR_Y, dy);
        cfg_write(CFG_PLANE_X, qx);
        cfg_write(CFG_PLANE_Y, qy);
        i_cfg_valid <= 0;
        @(posedge i_clk);
        pcx = int'(px >> 8);
        pcy = int'(py >> 8);
    endtask

    // random idle gap, then one word: mostly casts, writes cluster around
    // the player cell
    task automatic random_word(bit may_idle);
        int x, y;
        while (may_idle && $urandom_range(0, 99) < 24) begin
            start <= 0;
            @(posedge i_clk);
        end
        if ($urandom_range(0, 99) < 30) begin
            if ($urandom_range(0, 99) < 65) begin
                x = pcx + $urandom_range(0, 16) - 8;
                y = pcy + $urandom_range(0, 16) - 8;
                if (x < 0) x = 0;
                if (y < 0) y = 0;
                if (x > MAP_SIDE - 1) x = MAP_SIDE - 1;
                if (y > MAP_SIDE - 1) y = MAP_SIDE - 1;
            end else begin
                x = $urandom_range(0, MAP_SIDE - 1);
                y = $urandom_range(0, MAP_SIDE - 1);
            end
            put_cell(x, y, ($urandom_range(0, 99) < 70));
        end else if ($urandom_range(0, 9) == 0) begin
            cast(10'($urandom));          // includes columns past the screen
        end else begin
            cast(10'($urandom_range(0, SCREEN_WIDTH - 1)));
        end
    endtask

    initial begin
        int phase, n, sent;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: reset camera sits exactly on a grid line, so the first
        // x crossing is at distance zero and the span fills the column.
        put_cell(1, 2, 1);
        put_cell(2, 2, 1);                // player cell itself is never tested
        cast(10'd0);
        cast(10'd320);
        cast(10'd639);
        cast(10'd1023);
        put_cell(1, 2, 0);
        cast(10'd320);                    // runs off the map edge
        put_cell(63, 63, 1);
        put_cell(0, 0, 1);
        put_cell(0, 2, 1);
        cast(10'd320);
        drain();

        // zero y ray component: dir_y and plane_y both zero
        load_camera(14'd800, 14'd800, 16'h4000, 16'h0000, 16'h0000, 16'h0000);
        put_cell(10, 3, 1);
        cast(10'd0);
        cast(10'd500);
        drain();
        // extremes: far corner, largest positive direction and plane
        load_camera(14'h3FFF, 14'h3FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        cast(10'd0);
        cast(10'd639);
        drain();
        load_camera(14'h0000, 14'h0000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        put_cell(0, 1, 1);
        cast(10'd0);
        cast(10'd639);
        drain();

        sent = 0;
        for (phase = 0; phase < 9; phase++) begin
            case (phase % 3)
                0: load_camera(14'($urandom_range(256, 16127)),
                               14'($urandom_range(256, 16127)),
                               16'($urandom), 16'($urandom), 16'($urandom),
                               16'($urandom));
                1: load_camera(14'($urandom), 14'($urandom),
                               16'($signed($urandom_range(0, 32767)) - 16384),
                               16'($signed($urandom_range(0, 32767)) - 16384),
                               16'($signed($urandom_range(0, 21626)) - 10813),
                               16'($signed($urandom_range(0, 21626)) - 10813));
                default: load_camera(14'($urandom), 14'($urandom),
                                     16'h0000, 16'hC000, 16'h2A3D, 16'h0000);
            endcase
            for (n = 0; n < 148; n++) begin
                // a stretch of back-to-back words in the middle phase
                random_word(phase != 4);
                sent++;
            end
            drain();
        end

        if (fails == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("testbench NOT OK");
        $finish;
    end
endmodule

[filelist.f]
rtl/core/ddarc_pkg.sv
rtl/core/ddarc_ram.sv
rtl/core/ddarc_div.sv
rtl/core/ddarc_front.sv
rtl/core/ddarc_back.sv
rtl/core/dda_grid_raycast_column_core.sv
tb/sv/raycast_checker.sv
tb/sv/testbench.sv
